// ===== rtl/corner_state_index_defines.svh =====
// Assertion macros for the corner state index block.
// Each macro expects clk and arst_n to be in scope where it is used.
`ifndef CORNER_STATE_INDEX_DEFINES_SVH
`define CORNER_STATE_INDEX_DEFINES_SVH

// Same-cycle implication, checked only outside reset.
`define CSI_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("corner_state_index: check failed");

// Next-cycle implication, checked only outside reset.
`define CSI_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("corner_state_index: check failed");

`endif

// ===== rtl/csi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Corner state index package
// Widths, weight tables and constants shared by the interfaces and the block.
// ----------------------------------------------------------------------------
package csi_pkg;

	localparam int NUM_CORNERS   = 8;
	localparam int TWIST_CORNERS = 7;
	localparam int SLOT_W        = 3;
	localparam int TWIST_W       = 2;
	localparam int SLOTS_W       = NUM_CORNERS * SLOT_W;
	localparam int TWISTS_W      = TWIST_CORNERS * TWIST_W;
	localparam int RANK_W        = 16;
	localparam int TVAL_W        = 12;
	localparam int INDEX_W       = 27;

	// Number of twist combinations; the rank is scaled by this.
	localparam int TWIST_SPAN = 2187;

	// A twist code that does not name a real orientation.
	localparam logic [TWIST_W-1:0] TWIST_BAD = 2'd3;

	typedef logic [SLOTS_W-1:0]  slots_t;
	typedef logic [TWISTS_W-1:0] twists_t;
	typedef logic [INDEX_W-1:0]  index_t;

	// Factorial weight of each Lehmer digit, corner 0 most significant.
	localparam logic [RANK_W-1:0] FACT_WEIGHT [NUM_CORNERS] =
		'{16'd5040, 16'd720, 16'd120, 16'd24, 16'd6, 16'd2, 16'd1, 16'd1};

	// Base-3 weight of each twist digit, corner 0 most significant.
	localparam logic [TVAL_W-1:0] TWIST_WEIGHT [TWIST_CORNERS] =
		'{12'd729, 12'd243, 12'd81, 12'd27, 12'd9, 12'd3, 12'd1};

endpackage
`default_nettype wire

// ===== rtl/csi_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Corner state request channel
// Valid/ready channel that carries one corner state per request.
// ----------------------------------------------------------------------------
interface csi_req_if;
	import csi_pkg::*;

	logic    valid;
	logic    ready;
	slots_t  corner_slots;
	twists_t corner_twists;

	modport source (output valid, output corner_slots, output corner_twists, input ready);
	modport sink   (input valid, input corner_slots, input corner_twists, output ready);
endinterface
`default_nettype wire

// ===== rtl/csi_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Corner state response channel
// Valid/ready channel that carries one table index per request.
// ----------------------------------------------------------------------------
interface csi_rsp_if;
	import csi_pkg::*;

	logic   valid;
	logic   ready;
	index_t table_index;
	logic   invalid;

	modport source (output valid, output table_index, output invalid, input ready);
	modport sink   (input valid, input table_index, input invalid, output ready);
endinterface
`default_nettype wire

// ===== rtl/corner_state_index.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "corner_state_index_defines.svh"
// A request is captured in the input register, and its result then moves into
// the result register when that register is free or being drained.
// Throughput: one request per cycle; the request side stalls only while both
// registers are full and the result is not taken.
// Reset clears the two stage valid flags; the payload registers keep no reset.
// ----------------------------------------------------------------------------
// Corner state index
// Lehmer rank of the corner permutation times 2187 plus the base-3 twists.
// ----------------------------------------------------------------------------
module corner_state_index (
	input  wire logic clk,
	input  wire logic arst_n,
	csi_req_if.sink   req,
	csi_rsp_if.source rsp
);
	import csi_pkg::*;

	logic    v_s1;
	slots_t  slots_s1;
	twists_t twists_s1;
	logic    v_s2;
	index_t  index_s2;
	logic    invalid_s2;
	logic    adv_s2;
	logic    adv_s1;

	logic [SLOT_W-1:0]  slot  [NUM_CORNERS];
	logic [SLOT_W-1:0]  digit [NUM_CORNERS];
	logic [TWIST_W-1:0] twist [TWIST_CORNERS];
	logic [NUM_CORNERS-1:0] dup;
	logic [RANK_W-1:0]  rank;
	logic [TVAL_W-1:0]  tval;
	logic               twist_bad;
	logic               bad;
	index_t             index_c;

	// Both stages move when the result register is free or being drained; the input stage also moves while empty.
	assign adv_s2    = !v_s2 || rsp.ready;
	assign adv_s1    = !v_s1 || adv_s2;
	assign req.ready = adv_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && req.valid) begin
			slots_s1  <= req.corner_slots;
			twists_s1 <= req.corner_twists;
		end
	end

	// Split the fields into per-corner digits.
	always_comb begin
		for (int i = 0; i < NUM_CORNERS; i++) begin
			slot[i] = slots_s1[SLOT_W*i +: SLOT_W];
		end
		for (int i = 0; i < TWIST_CORNERS; i++) begin
			twist[i] = twists_s1[TWIST_W*i +: TWIST_W];
		end
	end

	// Lehmer digit of each corner: later corners holding a smaller slot.
	// A repeated slot is flagged at the earlier of the two corners.
	always_comb begin
		for (int i = 0; i < NUM_CORNERS; i++) begin
			digit[i] = '0;
			dup[i]   = 1'b0;
			for (int j = i + 1; j < NUM_CORNERS; j++) begin
				if (slot[j] < slot[i]) begin
					digit[i] = digit[i] + 3'd1;
				end
				if (slot[j] == slot[i]) begin
					dup[i] = 1'b1;
				end
			end
		end
	end

	// Weighted sums of the rank and twist digits.
	always_comb begin
		rank      = '0;
		tval      = '0;
		twist_bad = 1'b0;
		for (int i = 0; i < NUM_CORNERS; i++) begin
			rank = rank + RANK_W'(RANK_W'(digit[i]) * FACT_WEIGHT[i]);
		end
		for (int i = 0; i < TWIST_CORNERS; i++) begin
			tval = tval + TVAL_W'(TVAL_W'(twist[i]) * TWIST_WEIGHT[i]);
			if (twist[i] == TWIST_BAD) begin
				twist_bad = 1'b1;
			end
		end
	end

	// Scale the rank and merge in the twists; a rejected state gives zero.
	assign bad     = (|dup) || twist_bad;
	assign index_c = bad ? '0
		: index_t'(index_t'(rank) * index_t'(TWIST_SPAN) + index_t'(tval));

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			index_s2   <= index_c;
			invalid_s2 <= bad;
		end
	end

	assign rsp.valid       = v_s2;
	assign rsp.table_index = index_s2;
	assign rsp.invalid     = invalid_s2;

	// A rejected state always reports index zero.
	`CSI_ASSERT_NOW(a_invalid_zero, rsp.valid && rsp.invalid, rsp.table_index == '0)
	// A valid index stays inside the table.
	`CSI_ASSERT_NOW(a_index_range, rsp.valid && !rsp.invalid,
		rsp.table_index < index_t'(88179840))
	// An accepted request lands in the input stage.
	`CSI_ASSERT_NEXT(a_req_lands, req.valid && req.ready, v_s1)
	// A held input stage moves into the result register when it advances.
	`CSI_ASSERT_NEXT(a_s1_moves, v_s1 && adv_s2, rsp.valid)
	// The input stage holds its request while the result side is stalled.
	`CSI_ASSERT_NEXT(a_s1_holds, v_s1 && !adv_s2, v_s1 && $stable(slots_s1))

endmodule
`default_nettype wire
